### rtl/core/mcsa_pkg.sv
`timescale 1ns / 1ps
package mcsa_pkg;
  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam logic [2:0] REG_NUM_CLASSES  = 3'd0;
  localparam logic [2:0] REG_TOTAL_BYTES  = 3'd1;
  localparam logic [2:0] REG_BASE_ADDRESS = 3'd2;
  localparam logic [2:0] REG_CLASS_SIZES  = 3'd3;
  localparam logic [2:0] REG_CLASS_COUNTS = 3'd4;

  localparam int unsigned SizeW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned UsedW   = 11;
  localparam logic [31:0] AlignMask = 32'd3;

  // Control from the sequencer to the divide unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [16:0] remainder;
  } div_rsp_t;
endpackage

### rtl/core/mcsa_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module mcsa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcsa_pkg::div_req_t req_i,
  output mcsa_pkg::div_rsp_t rsp_o
);
  import mcsa_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] dvs_q, dvs_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q[16:0], quo_q[31]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[16:0];
endmodule

### rtl/core/multi_class_slab_allocator.sv
`timescale 1ns / 1ps
// Slab allocator with up to MAX_CLASSES size classes, each a LIFO free stack held in
// one memory. Items are handled one at a time, and the input is not ready while a
// configuration write is offered. An alloc scans one class per cycle, then reads the
// stack and forms the product, then forms the address and sums the totals. A free
// scans the classes the same way and then waits on the bit-serial divider for the
// block index and alignment. An init lays out each class and writes its stack one
// entry per cycle. A result sits in the output register until taken.
module multi_class_slab_allocator #(
  parameter int unsigned MAX_CLASSES   = 4,
  parameter int unsigned MAX_BLOCKS    = 256,
  parameter int unsigned POINTER_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] request_size_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [31:0] block_address_o,
  output logic [31:0] bytes_in_use_o,
  output logic [10:0] used_blocks_o
);
  import mcsa_pkg::*;

  localparam int unsigned CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned DEP = MAX_CLASSES * MAX_BLOCKS;
  localparam int unsigned IW  = (DEP > 1) ? $clog2(DEP) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_CLS, S_INIT_FILL, S_ALLOC_SCAN, S_ALLOC_RD, S_ALLOC_MUL,
    S_FREE_SCAN, S_FREE_DIV, S_SUM, S_OUT
  } state_e;

  state_e state_q;

  logic [2:0]  num_classes_q;
  logic [31:0] total_bytes_q, base_address_q;
  logic [63:0] class_sizes_q, class_counts_q;

  logic [NW-1:0] free_count_q [MAX_CLASSES];
  logic [16:0]   bsize_q      [MAX_CLASSES];
  logic [NW-1:0] total_q      [MAX_CLASSES];
  logic [31:0]   start_q      [MAX_CLASSES];
  logic [3:0]    active_q;

  logic [BW-1:0] stack_mem [DEP];
  logic [BW-1:0] rd_data_q;

  logic [3:0]    ci_q;
  logic [NW-1:0] fj_q;
  logic [31:0]   curr_q;
  logic [32:0]   remain_q;
  logic [15:0]   req_size_q;
  logic [31:0]   faddr_q;
  logic          st_q;
  logic [31:0]   addr_q, bytes_q;
  logic [10:0]   used_q;
  logic          rd_wait_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mcsa_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = (state_q == S_OUT);

  logic [CW-1:0] cidx;
  assign cidx = ci_q[CW-1:0];

  logic [16:0] round_sz;
  logic [15:0] cnt16, sz16;
  logic [32:0] req_bytes;
  logic [31:0] off_c;
  logic [32:0] span_c;
  always_comb begin
    // The size and count registers hold four classes; any later class reads as zero.
    sz16  = (ci_q < 4'd4) ? class_sizes_q[16*ci_q[1:0] +: 16] : 16'd0;
    cnt16 = (ci_q < 4'd4) ? class_counts_q[16*ci_q[1:0] +: 16] : 16'd0;
    round_sz = ({1'b0, sz16} + 17'd3) & ~17'(AlignMask);
    if (round_sz < 17'(POINTER_BYTES)) round_sz = 17'(POINTER_BYTES);
    req_bytes = 33'(round_sz) * 33'(cnt16);
    off_c  = faddr_q - start_q[cidx];
    span_c = 33'(bsize_q[cidx]) * 33'(total_q[cidx]);
  end

  logic in_range;
  assign in_range = (ci_q < 4'(MAX_CLASSES)) && (ci_q < active_q);

  always_comb begin
    div_req.start    = (state_q == S_FREE_SCAN) && in_range && bsize_q[cidx] != 17'd0
                       && ({1'b0, off_c} < span_c) && faddr_q != 32'd0;
    div_req.dividend = off_c;
    div_req.divisor  = bsize_q[cidx];
  end

  logic [IW-1:0] fill_addr, push_addr, top_addr;
  assign fill_addr = IW'(cidx) * IW'(MAX_BLOCKS) + IW'(fj_q);
  assign push_addr = IW'(cidx) * IW'(MAX_BLOCKS) + IW'(free_count_q[cidx]);
  assign top_addr  = IW'(cidx) * IW'(MAX_BLOCKS) + IW'(free_count_q[cidx] - NW'(1));

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT_FILL && fj_q < total_q[cidx])
      stack_mem[fill_addr] <= fj_q[BW-1:0];
    else if (state_q == S_FREE_DIV && div_rsp.done && div_rsp.remainder == 17'd0
             && free_count_q[cidx] < total_q[cidx])
      stack_mem[push_addr] <= div_rsp.quotient[BW-1:0];
    rd_data_q <= stack_mem[top_addr];
  end

  logic [31:0] prod_q;
  always_ff @(posedge clk_i) prod_q <= 32'(rd_data_q) * 32'(bsize_q[cidx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      num_classes_q <= 3'd1;
      total_bytes_q <= '0; base_address_q <= '0;
      class_sizes_q <= '0; class_counts_q <= '0;
      active_q <= '0;
      for (int k = 0; k < MAX_CLASSES; k++) begin
        free_count_q[k] <= '0; bsize_q[k] <= '0; total_q[k] <= '0; start_q[k] <= '0;
      end
      ci_q <= '0; fj_q <= '0; curr_q <= '0; remain_q <= '0; req_size_q <= '0;
      faddr_q <= '0; st_q <= 1'b0; addr_q <= '0; bytes_q <= '0;
      used_q <= '0; rd_wait_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              REG_NUM_CLASSES:  num_classes_q <= cfg_data_i[2:0];
              REG_TOTAL_BYTES:  total_bytes_q <= cfg_data_i[31:0];
              REG_BASE_ADDRESS: base_address_q <= cfg_data_i[31:0];
              REG_CLASS_SIZES:  class_sizes_q <= cfg_data_i;
              REG_CLASS_COUNTS: class_counts_q <= cfg_data_i;
              default: ;
            endcase
          end else if (in_valid_i) begin
            ci_q <= '0; fj_q <= '0; st_q <= 1'b1; addr_q <= '0;
            req_size_q <= request_size_i; faddr_q <= free_address_i;
            case (action_e'(action_i))
              ACT_INIT: begin
                if (num_classes_q == 3'd0 || 32'(num_classes_q) > MAX_CLASSES
                    || base_address_q == 32'd0) begin
                  state_q <= S_SUM;
                end else begin
                  for (int k = 0; k < MAX_CLASSES; k++) begin
                    free_count_q[k] <= '0; bsize_q[k] <= '0;
                    total_q[k] <= '0; start_q[k] <= '0;
                  end
                  active_q <= {1'b0, num_classes_q};
                  curr_q <= base_address_q;
                  remain_q <= {1'b0, total_bytes_q};
                  state_q <= S_INIT_CLS;
                end
              end
              ACT_ALLOC: state_q <= (request_size_i == 16'd0) ? S_SUM : S_ALLOC_SCAN;
              ACT_FREE:  state_q <= S_FREE_SCAN;
              default:   state_q <= S_SUM;
            endcase
          end
        end
        S_INIT_CLS: begin
          if (ci_q >= active_q) begin
            st_q <= 1'b0; state_q <= S_SUM;
          end else if (32'(cnt16) > MAX_BLOCKS || req_bytes > remain_q) begin
            state_q <= S_SUM;
          end else begin
            bsize_q[cidx] <= round_sz;
            total_q[cidx] <= NW'(cnt16);
            free_count_q[cidx] <= NW'(cnt16);
            start_q[cidx] <= curr_q;
            curr_q <= curr_q + req_bytes[31:0];
            remain_q <= remain_q - req_bytes;
            fj_q <= '0;
            state_q <= S_INIT_FILL;
          end
        end
        S_INIT_FILL: begin
          if (fj_q < total_q[cidx]) fj_q <= fj_q + NW'(1);
          else begin
            ci_q <= ci_q + 4'd1; state_q <= S_INIT_CLS;
          end
        end
        S_ALLOC_SCAN: begin
          if (!in_range) state_q <= S_SUM;
          else if (bsize_q[cidx] >= {1'b0, req_size_q} && free_count_q[cidx] != '0) begin
            rd_wait_q <= 1'b0; state_q <= S_ALLOC_RD;
          end else ci_q <= ci_q + 4'd1;
        end
        S_ALLOC_RD: begin
          // Waits for the registered stack read and then for the product register.
          rd_wait_q <= 1'b1;
          if (rd_wait_q) state_q <= S_ALLOC_MUL;
        end
        S_ALLOC_MUL: begin
          addr_q <= start_q[cidx] + prod_q;
          free_count_q[cidx] <= free_count_q[cidx] - NW'(1);
          st_q <= 1'b0; state_q <= S_SUM;
        end
        S_FREE_SCAN: begin
          if (faddr_q == 32'd0 || !in_range) state_q <= S_SUM;
          else if (div_req.start) state_q <= S_FREE_DIV;
          else ci_q <= ci_q + 4'd1;
        end
        S_FREE_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == 17'd0 && free_count_q[cidx] < total_q[cidx]) begin
              free_count_q[cidx] <= free_count_q[cidx] + NW'(1);
              st_q <= 1'b0;
            end
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          state_q <= S_OUT;
          begin : sum_blk
            logic [31:0] b;
            logic [10:0] u;
            b = '0; u = '0;
            for (int k = 0; k < MAX_CLASSES; k++) begin
              if (4'(k) < active_q) begin
                b = b + 32'(total_q[k] - free_count_q[k]) * 32'(bsize_q[k]);
                u = u + 11'(total_q[k] - free_count_q[k]);
              end
            end
            bytes_q <= b; used_q <= u;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o          = st_q;
  assign block_address_o   = addr_q;
  assign bytes_in_use_o    = bytes_q;
  assign used_blocks_o     = used_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(block_address_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> block_address_o == 32'd0)
    else $error("failed item carries an address");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("accepting while a result waits");
endmodule
